[rtl/tsm_pkg.sv]
// package: beat types, codes and constants of the template string matcher
`default_nettype none
package tsm_pkg;

   // program and register geometry
   localparam int STEPS_MAX    = 16;
   localparam int LEN_BITS_DEF = 16;
   localparam int STEP_W       = 5;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [1:0] {
      STEP_END    = 2'd0,
      STEP_FIXED  = 2'd1,
      STEP_NUMBER = 2'd2,
      STEP_DELIM  = 2'd3
   } step_kind_type;

   typedef enum logic [1:0] {
      RES_NUMBER  = 2'd0,
      RES_FIELD   = 2'd1,
      RES_VERDICT = 2'd2
   } res_kind_type;

   typedef enum logic [1:0] {
      REG_STEP_KINDS = 2'd0,
      REG_CHARS_LOW  = 2'd1,
      REG_CHARS_HIGH = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_END,
      ST_VERDICT
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  step_number;
      logic [63:0] number_value;
      logic [15:0] field_start;
      logic [15:0] field_length;
      logic        matched;
      logic        final_res;
   } rsp_payload_type;

endpackage
`default_nettype wire

[rtl/template_string_matcher.sv]
// top level: template string matcher, one program step per cycle barring stalls
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+------------------------------
//  req      | req_valid, req_ready, req_payload       | one byte of the string
//  rsp      | rsp_valid, rsp_ready, rsp_payload       | one number, field or verdict
//  csr      | csr_psel/penable/pwrite/paddr/pwdata... | 64-bit register at 8*index
//
//  a byte is accepted, then visits the program steps in turn (usually one,
//  more where a number step ends and hands the byte on); after the last
//  byte each number step left emits its number, the walk stops at the end
//  step (first marking a failing fixed or field step) and the verdict follows.
//  the rate is set by the single step evaluator walking the program.
//  reset is synchronous, active high; it clears the program and match state.
//  a result waits in the output register; the sequencer stalls only when
//  it must emit a new result while that register is still full.
`default_nettype none
module template_string_matcher #(
   parameter int MAX_STEPS = tsm_pkg::STEPS_MAX,
   parameter int LEN_BITS  = tsm_pkg::LEN_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // byte input
   input  wire                              req_valid,
   output logic                             req_ready,
   input  tsm_pkg::req_payload_type         req_payload,
   // results
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output tsm_pkg::rsp_payload_type         rsp_payload,
   // register port
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [tsm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [tsm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tsm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import tsm_pkg::*;

   // program registers
   logic [31:0]          kinds_ff;
   logic [63:0]          chars_lo_ff;
   logic [63:0]          chars_hi_ff;

   // match state
   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [63:0]          acc_ff, acc_in;
   logic [LEN_BITS-1:0]  pos_ff, pos_in;
   logic [LEN_BITS-1:0]  fbeg_ff, fbeg_in;
   logic                 failed_ff, failed_in;

   // latched beat
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   // step evaluator
   logic                 csr_wr;
   reg_index_type        csr_idx;
   logic                 req_fire;
   logic                 slot_free;
   logic                 step_past;
   logic [3:0]           step_idx;
   step_kind_type        step_kind;
   logic [127:0]         chars_all;
   logic [7:0]           step_char;
   logic                 char_hit;
   logic                 is_digit;
   logic [63:0]          acc_digit;
   logic [LEN_BITS-1:0]  pos_inc;
   logic                 pos_max;
   logic                 emit_en;
   rsp_payload_type      num_res, field_res, verdict_res;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_idx)
         REG_STEP_KINDS: csr_prdata = {32'd0, kinds_ff};
         REG_CHARS_LOW:  csr_prdata = chars_lo_ff;
         REG_CHARS_HIGH: csr_prdata = chars_hi_ff;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kinds_ff    <= '0;
         chars_lo_ff <= '0;
         chars_hi_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_STEP_KINDS: kinds_ff    <= csr_pwdata[31:0];
            REG_CHARS_LOW:  chars_lo_ff <= csr_pwdata;
            REG_CHARS_HIGH: chars_hi_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // ---------------- step decode ----------------
   // a step index at or past the program length behaves as an end step
   assign step_past = step_ff >= STEP_W'(MAX_STEPS);
   assign step_idx  = step_ff[3:0];
   assign step_kind = step_past ? STEP_END : step_kind_type'(kinds_ff[2*step_idx +: 2]);
   assign chars_all = {chars_hi_ff, chars_lo_ff};
   assign step_char = chars_all[8*step_idx +: 8];
   assign char_hit  = byte_ff == step_char;
   assign is_digit  = (byte_ff >= CHAR_ZERO) && (byte_ff <= CHAR_NINE);

   // acc * 10 + digit as shift-add, wraps modulo 2^64
   assign acc_digit = (acc_ff << 3) + (acc_ff << 1) + {56'd0, byte_ff - CHAR_ZERO};

   assign pos_inc   = pos_ff + LEN_BITS'(1);
   assign pos_max   = &pos_ff;

   // results the sequencer may load into the output register
   always_comb begin
      num_res              = '0;
      num_res.kind         = RES_NUMBER;
      num_res.step_number  = step_idx;
      num_res.number_value = acc_ff;

      field_res              = '0;
      field_res.kind         = RES_FIELD;
      field_res.step_number  = step_idx;
      field_res.field_start  = 16'(fbeg_ff);
      field_res.field_length = 16'(LEN_BITS'(pos_ff - fbeg_ff));

      verdict_res           = '0;
      verdict_res.kind      = RES_VERDICT;
      verdict_res.matched   = !failed_ff;
      verdict_res.final_res = 1'b1;
   end

   // output register can take a new result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      fbeg_in      = fbeg_ff;
      failed_in    = failed_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      emit_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               byte_in  = req_payload.data_byte;
               last_in  = req_payload.last_byte;
               state_in = req_payload.last_byte ? ST_END : ST_IDLE;
               if (req_payload.has_byte) begin
                  if (pos_max) begin
                     // overlong string, position saturates
                     failed_in = 1'b1;
                  end else if (failed_ff) begin
                     pos_in = pos_inc;
                  end else begin
                     state_in = ST_RUN;
                  end
               end
            end
         end

         ST_RUN: begin
            case (step_kind)
               STEP_END: begin
                  failed_in = 1'b1;
                  pos_in    = pos_inc;
                  state_in  = last_ff ? ST_END : ST_IDLE;
               end
               STEP_FIXED: begin
                  if (char_hit) begin
                     step_in = step_ff + STEP_W'(1);
                     fbeg_in = pos_inc;
                  end else begin
                     failed_in = 1'b1;
                  end
                  pos_in   = pos_inc;
                  state_in = last_ff ? ST_END : ST_IDLE;
               end
               STEP_NUMBER: begin
                  if (is_digit) begin
                     acc_in   = acc_digit;
                     pos_in   = pos_inc;
                     state_in = last_ff ? ST_END : ST_IDLE;
                  end else if (slot_free) begin
                     // number ends, same byte goes on to the next step
                     emit_en = 1'b1;
                     rsp_in  = num_res;
                     acc_in  = '0;
                     step_in = step_ff + STEP_W'(1);
                     fbeg_in = pos_ff;
                  end
               end
               STEP_DELIM: begin
                  if (!char_hit) begin
                     pos_in   = pos_inc;
                     state_in = last_ff ? ST_END : ST_IDLE;
                  end else if (slot_free) begin
                     emit_en  = 1'b1;
                     rsp_in   = field_res;
                     step_in  = step_ff + STEP_W'(1);
                     fbeg_in  = pos_inc;
                     pos_in   = pos_inc;
                     state_in = last_ff ? ST_END : ST_IDLE;
                  end
               end
               default: ;
            endcase
         end

         ST_END: begin
            // remaining steps run with no data
            if (failed_ff || (step_kind == STEP_END)) begin
               state_in = ST_VERDICT;
            end else if (step_kind == STEP_NUMBER) begin
               if (slot_free) begin
                  emit_en = 1'b1;
                  rsp_in  = num_res;
                  acc_in  = '0;
                  step_in = step_ff + STEP_W'(1);
                  fbeg_in = pos_ff;
               end
            end else begin
               failed_in = 1'b1;
            end
         end

         ST_VERDICT: begin
            if (slot_free) begin
               emit_en   = 1'b1;
               rsp_in    = verdict_res;
               step_in   = '0;
               acc_in    = '0;
               pos_in    = '0;
               fbeg_in   = '0;
               failed_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (emit_en) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         fbeg_ff      <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         fbeg_ff      <= fbeg_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- checks ----------------
   // a new result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit_en |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending beat");

   // the verdict returns the match state to its reset values
   a_verdict_clears: assert property (@(posedge clock) disable iff (reset)
      (emit_en && (state_ff == ST_VERDICT)) |=>
         (step_ff == '0) && (pos_ff == '0) && (acc_ff == '0) && !failed_ff
         && (state_ff == ST_IDLE))
      else $error("state not cleared after verdict");

   // only the verdict carries final_res, and no other result sets matched
   a_verdict_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.kind == RES_VERDICT) == rsp_ff.final_res)
         && (rsp_ff.final_res || !rsp_ff.matched))
      else $error("malformed result beat");

   // bytes are taken only between items
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !req_ready)
      else $error("byte accepted while a step is running");

endmodule
`default_nettype wire

[tb/template_string_matcher_tb.sv]
// testbench: template string matcher checked beat by beat against a match predictor
module template_string_matcher_tb;
   import tsm_pkg::*;

   // run limits and phase sizes
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_BEATS  = 360;
   localparam int PHASE_BEATS   = 30;
   localparam int QUIET_BEATS   = 80;
   localparam int HOLD_CYCLES   = 300;

   // predictor of the matcher: program copy, match state and the results still owed
   class match_tracker;
      logic [31:0]             kinds;
      logic [63:0]             chars_lo;
      logic [63:0]             chars_hi;
      logic [STEP_W-1:0]       cur_step;
      logic [63:0]             acc;
      logic [LEN_BITS_DEF-1:0] pos;
      logic [LEN_BITS_DEF-1:0] fbegin;
      bit                      failed;
      rsp_payload_type         owed_fields[$];
      int unsigned             errors;
      int unsigned             results_seen;

      function new();
         kinds = '0;
         chars_lo = '0;
         chars_hi = '0;
         errors = 0;
         results_seen = 0;
         clear_match();
      endfunction

      function void clear_match();
         cur_step = '0;
         acc = '0;
         pos = '0;
         fbegin = '0;
         failed = 1'b0;
      endfunction

      function void set_reg(reg_index_type idx, logic [63:0] value);
         case (idx)
            REG_STEP_KINDS: kinds = value[31:0];
            REG_CHARS_LOW:  chars_lo = value;
            REG_CHARS_HIGH: chars_hi = value;
            default: ;
         endcase
      endfunction

      function step_kind_type step_kind(logic [STEP_W-1:0] s);
         if (s >= STEPS_MAX) return STEP_END;
         return step_kind_type'(kinds[2*s +: 2]);
      endfunction

      function logic [7:0] step_char(logic [STEP_W-1:0] s);
         if (s < 8) return chars_lo[8*s +: 8];
         return chars_hi[8*(s-8) +: 8];
      endfunction

      function void push_result(res_kind_type k, logic [3:0] step, logic [63:0] value,
                                logic [15:0] start, logic [15:0] len, logic ok, logic fin);
         rsp_payload_type r;
         r.kind = k;
         r.step_number = step;
         r.number_value = value;
         r.field_start = start;
         r.field_length = len;
         r.matched = ok;
         r.final_res = fin;
         owed_fields.push_back(r);
      endfunction

      // one byte walks the program; a number that ends hands the byte on
      function void feed_byte(logic [7:0] b);
         bit            done;
         step_kind_type k;
         done = 1'b0;
         while (!done) begin
            k = step_kind(cur_step);
            case (k)
               STEP_END: begin
                  failed = 1'b1;
                  done = 1'b1;
               end
               STEP_FIXED: begin
                  if (b == step_char(cur_step)) begin
                     cur_step = cur_step + 1'b1;
                     fbegin = pos + 1'b1;
                  end else begin
                     failed = 1'b1;
                  end
                  done = 1'b1;
               end
               STEP_NUMBER: begin
                  if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                     acc = acc * 10 + 64'(b - CHAR_ZERO);
                     done = 1'b1;
                  end else begin
                     push_result(RES_NUMBER, cur_step[3:0], acc, '0, '0, 1'b0, 1'b0);
                     acc = '0;
                     cur_step = cur_step + 1'b1;
                     fbegin = pos;
                  end
               end
               default: begin
                  if (b == step_char(cur_step)) begin
                     push_result(RES_FIELD, cur_step[3:0], '0, fbegin, pos - fbegin,
                                 1'b0, 1'b0);
                     cur_step = cur_step + 1'b1;
                     fbegin = pos + 1'b1;
                  end
                  done = 1'b1;
               end
            endcase
         end
      endfunction

      function void note_beat(req_payload_type p);
         if (p.has_byte) begin
            if (&pos) begin
               failed = 1'b1;
            end else begin
               if (!failed) feed_byte(p.data_byte);
               pos = pos + 1'b1;
            end
         end
         if (p.last_byte) begin
            while (!failed && step_kind(cur_step) != STEP_END) begin
               if (step_kind(cur_step) == STEP_NUMBER) begin
                  push_result(RES_NUMBER, cur_step[3:0], acc, '0, '0, 1'b0, 1'b0);
                  acc = '0;
                  cur_step = cur_step + 1'b1;
                  fbegin = pos;
               end else begin
                  failed = 1'b1;
               end
            end
            push_result(RES_VERDICT, '0, '0, '0, '0, !failed, 1'b1);
            clear_match();
         end
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task compare_one(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
      endtask

      task check_field(rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         if (owed_fields.size() == 0) begin
            report($sformatf("result %0d arrived with nothing outstanding", results_seen));
         end else begin
            want = owed_fields.pop_front();
            compare_one("kind", got.kind, want.kind);
            compare_one("step_number", got.step_number, want.step_number);
            compare_one("number_value", got.number_value, want.number_value);
            compare_one("field_start", got.field_start, want.field_start);
            compare_one("field_length", got.field_length, want.field_length);
            compare_one("matched", got.matched, want.matched);
            compare_one("final_res", got.final_res, want.final_res);
         end
      endtask
   endclass

   // clock, reset and every block input known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   match_tracker  tracker;

   // program under test as the stimulus side sees it
   step_kind_type prog_kind [STEPS_MAX];
   logic [7:0]    prog_char [STEPS_MAX];
   logic [7:0]    text_q[$];

   bit            no_idle = 1'b0;    // set for the stretch with no gaps on either side
   int unsigned   hold_left = 0;     // output hold-off, counted down by the result sink
   int unsigned   counted_beats = 0; // beats carrying a byte or an end mark
   int unsigned   strings_sent = 0;
   int unsigned   programs_loaded = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   template_string_matcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // one register write: setup phase, then access until pready; the caller
   // lowers psel after its last write so back-to-back writes stay legal
   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(idx, value);
   endtask

   // pack the program arrays into the three registers
   task automatic load_program();
      logic [31:0] kinds;
      logic [63:0] lo;
      logic [63:0] hi;
      kinds = '0;
      lo = '0;
      hi = '0;
      for (int s = 0; s < STEPS_MAX; s++) begin
         kinds[2*s +: 2] = prog_kind[s];
         if (s < 8) lo[8*s +: 8] = prog_char[s];
         else hi[8*(s-8) +: 8] = prog_char[s];
      end
      csr_write(REG_STEP_KINDS, {32'd0, kinds});
      csr_write(REG_CHARS_LOW, lo);
      csr_write(REG_CHARS_HIGH, hi);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      programs_loaded++;
   endtask

   task automatic fill_program(input step_kind_type k, input logic [7:0] c_lo,
                               input logic [7:0] c_hi);
      for (int s = 0; s < STEPS_MAX; s++) begin
         prog_kind[s] = k;
         prog_char[s] = (s < 8) ? c_lo : c_hi;
      end
   endtask

   // random program: 1..16 live steps, sometimes junk behind the end step;
   // a full sixteen leaves no end step, so matching runs past the program
   task automatic random_program();
      int n;
      n = $urandom_range(1, STEPS_MAX);
      for (int s = 0; s < STEPS_MAX; s++) begin
         if (s < n) prog_kind[s] = step_kind_type'($urandom_range(1, 3));
         else if (s > n && $urandom_range(99) < 30)
            prog_kind[s] = step_kind_type'($urandom_range(0, 3));
         else prog_kind[s] = STEP_END;
         prog_char[s] = $urandom_range(1) ? 8'($urandom_range(33, 126)) : 8'($urandom);
      end
   endtask

   // offer one beat; valid stays up with the same payload until accepted
   task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
      req_payload_type p;
      p.data_byte = b;
      p.has_byte = has;
      p.last_byte = last;
      if (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      tracker.note_beat(p);
      if (has || last) counted_beats++;
   endtask

   // send text_q as one string; the end mark rides on the last byte or,
   // when split_end is set or the string is empty, on a byte-less beat
   task automatic send_string(input bit split_end);
      for (int i = 0; i < text_q.size(); i++) begin
         // an occasional beat with neither byte nor end mark, which does nothing
         if ($urandom_range(99) < 4) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(text_q[i], 1'b1, !split_end && i == text_q.size() - 1);
      end
      if (split_end || text_q.size() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
      strings_sent++;
   endtask

   task automatic set_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // a string that the current program should match, random content inside
   task automatic build_wellformed();
      int         n;
      logic [7:0] c;
      text_q.delete();
      for (int s = 0; s < STEPS_MAX; s++) begin
         if (prog_kind[s] == STEP_END) break;
         case (prog_kind[s])
            STEP_FIXED: text_q.push_back(prog_char[s]);
            STEP_NUMBER: begin
               // mostly short numbers, some long enough to wrap 64 bits
               n = ($urandom_range(99) < 20) ? $urandom_range(15, 24) : $urandom_range(0, 4);
               repeat (n) text_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
            end
            STEP_DELIM: begin
               repeat ($urandom_range(0, 5)) begin
                  do c = 8'($urandom); while (c == prog_char[s]);
                  text_q.push_back(c);
               end
               text_q.push_back(prog_char[s]);
            end
            default: ;
         endcase
      end
   endtask

   // break a well-formed string: cut its tail, corrupt a byte or add junk
   task automatic mutate_text();
      int how;
      how = $urandom_range(2);
      if (how == 0) begin
         repeat ($urandom_range(1, 4)) if (text_q.size() > 0) void'(text_q.pop_back());
      end else if (how == 1) begin
         if (text_q.size() > 0) text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom);
      end else begin
         repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
      end
   endtask

   // short noise mixing arbitrary bytes, program chars and digits
   task automatic build_noise();
      text_q.delete();
      repeat ($urandom_range(0, 6))
         text_q.push_back($urandom_range(1) ? 8'($urandom) :
                          $urandom_range(1) ? prog_char[$urandom_range(STEPS_MAX - 1)] :
                                              CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   // every owed result back, then a margin for byte-only beats still in flight
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.owed_fields.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result sink: random backpressure, a long hold when asked, check each beat
   initial begin : result_sink
      forever begin
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 6);
         end
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_field(rsp_payload);
      end
   end

   // watchdog over the whole run
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               CYCLE_LIMIT, tracker.owed_fields.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned p;
      int unsigned pick;
      int unsigned phase_start;
      int unsigned phase_len;
      int unsigned random_start;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every step a number: the empty string emits sixteen zeros and the
      // verdict; a non-digit ends one number and chains through all the rest,
      // then runs past the program and fails
      fill_program(STEP_NUMBER, 8'h00, 8'h00);
      load_program();
      set_text("");
      send_string(1'b0);
      set_text("12a");
      send_string(1'b0);
      drain();

      // all end steps: any data fails, the empty string matches
      fill_program(STEP_END, 8'hFF, 8'hFF);
      load_program();
      set_text("a");
      send_string(1'b0);
      set_text("");
      send_string(1'b0);
      drain();

      // fixed 'G', number, field up to '/', fixed 'x'
      fill_program(STEP_END, 8'h00, 8'h00);
      prog_kind[0] = STEP_FIXED;
      prog_char[0] = "G";
      prog_kind[1] = STEP_NUMBER;
      prog_kind[2] = STEP_DELIM;
      prog_char[2] = "/";
      prog_kind[3] = STEP_FIXED;
      prog_char[3] = "x";
      load_program();
      set_text("G42ab/x");
      send_string(1'b0);
      set_text("G1/x");              // empty field, end mark on its own beat
      send_string(1'b1);
      set_text("G7");                // number flushed at the end, field step fails
      send_string(1'b0);
      send_beat(8'hA5, 1'b0, 1'b0);  // no byte and no end mark
      set_text("Zq");                // early failure, second byte ignored
      send_string(1'b0);
      drain();

      // random programs; first phase is all delimited fields with the
      // extreme delimiter bytes, one phase runs without any idling and one
      // holds the output long enough to back the block up into its input
      random_start = counted_beats;
      p = 0;
      while (counted_beats - random_start < RANDOM_BEATS) begin
         if (p == 0) fill_program(STEP_DELIM, 8'h00, 8'hFF);
         else random_program();
         load_program();
         no_idle = (p == 2);
         if (p == 4) hold_left = HOLD_CYCLES;
         phase_len = (p == 2) ? QUIET_BEATS : PHASE_BEATS;
         phase_start = counted_beats;
         while (counted_beats - phase_start < phase_len) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               build_wellformed();
            end else if (pick < 85) begin
               build_wellformed();
               mutate_text();
            end else begin
               build_noise();
            end
            send_string($urandom_range(99) < 30);
         end
         drain();
         p++;
      end
      no_idle = 1'b0;

      $display("covered %0d strings over %0d programs, %0d beats in, %0d results checked",
               strings_sent, programs_loaded, counted_beats, tracker.results_seen);
      $display("incl. chained numbers, past-program runs, empty strings and output hold-off");
      if (tracker.errors == 0 && tracker.owed_fields.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
